// File: rtl/core/xmodem_crc_receiver_defines.svh
// Assertion macros for the XMODEM-CRC receiver.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef XMODEM_CRC_RECEIVER_DEFINES_SVH
`define XMODEM_CRC_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define XCR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xcr assertion failed (same cycle)");

// Next-cycle implication, disabled while in reset.
`define XCR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xcr assertion failed (next cycle)");

`endif

// File: rtl/core/xcr_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the receiver.
// No dependencies; used by xcr_core and xmodem_crc_receiver.
package xcr_pkg;

    localparam int BLOCK_BYTES    = 128;
    localparam int BIDX_W         = $clog2(BLOCK_BYTES);
    localparam int PAGE_BYTES_DEF = 256;
    localparam int PAGE_BITS_DEF  = 12;

    localparam int PROMPT_W = 20;
    localparam logic [PROMPT_W-1:0] PROMPT_RESET = 20'd500000;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_C   = 8'h43;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int OUT_BITS = 42;
    localparam int TDATA_W  = 48;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NUMBER,
        PH_COMPL,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_DONE
    } xcr_phase_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } xcr_item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        load_valid;
        logic        store_valid;
        logic [7:0]  store_offset;
        logic [7:0]  store_data;
        logic        commit_valid;
        logic        buffer_id;
        logic [11:0] flash_page;
        logic        done_res;
    } xcr_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/xcr_core.sv
// Protocol state machine of the XMODEM-CRC receiver: phase, CRC, block and page tracking.
// Depends on xcr_pkg; one word is processed in each cycle that step is high.
module xcr_core #(
    parameter int PAGE_BYTES = xcr_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_BITS  = xcr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  xcr_pkg::xcr_item_t            item,
    input  logic [xcr_pkg::PROMPT_W-1:0]  prompt_interval,
    output xcr_pkg::xcr_result_t          result
);

    localparam int OFS_W = $clog2(PAGE_BYTES + xcr_pkg::BLOCK_BYTES);

    xcr_pkg::xcr_phase_t phase_reg, phase_next;
    logic                          started_reg, started_next;
    logic                          finished_reg, finished_next;
    logic [xcr_pkg::PROMPT_W-1:0]  countdown_reg, countdown_next;
    logic [15:0]                   crc_reg, crc_next;
    logic [7:0]                    check_hi_reg, check_hi_next;
    logic [7:0]                    block_reg, block_next;
    logic [7:0]                    prev_block_reg, prev_block_next;
    logic [xcr_pkg::BIDX_W-1:0]    byte_index_reg, byte_index_next;
    logic [OFS_W-1:0]              offset_reg, offset_next;
    logic [PAGE_BITS-1:0]          page_reg, page_next;
    logic                          buf_sel_reg, buf_sel_next;
    logic                          need_load_reg, need_load_next;

    logic [xcr_pkg::PROMPT_W-1:0]  count_base;
    logic [OFS_W-1:0]              offset_adv;
    logic [15:0]                   page_ext;
    logic [7:0]                    b;

    assign b          = item.rx_byte;
    assign offset_adv = offset_reg + OFS_W'(xcr_pkg::BLOCK_BYTES);
    assign page_ext   = 16'(page_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= xcr_pkg::PH_HEADER;
            started_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            countdown_reg  <= '0;
            crc_reg        <= '0;
            check_hi_reg   <= '0;
            block_reg      <= '0;
            prev_block_reg <= '0;
            byte_index_reg <= '0;
            offset_reg     <= '0;
            page_reg       <= '0;
            buf_sel_reg    <= 1'b0;
            need_load_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            started_reg    <= started_next;
            finished_reg   <= finished_next;
            countdown_reg  <= countdown_next;
            crc_reg        <= crc_next;
            check_hi_reg   <= check_hi_next;
            block_reg      <= block_next;
            prev_block_reg <= prev_block_next;
            byte_index_reg <= byte_index_next;
            offset_reg     <= offset_next;
            page_reg       <= page_next;
            buf_sel_reg    <= buf_sel_next;
            need_load_reg  <= need_load_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        started_next    = started_reg;
        finished_next   = finished_reg;
        countdown_next  = countdown_reg;
        crc_next        = crc_reg;
        check_hi_next   = check_hi_reg;
        block_next      = block_reg;
        prev_block_next = prev_block_reg;
        byte_index_next = byte_index_reg;
        offset_next     = offset_reg;
        page_next       = page_reg;
        buf_sel_next    = buf_sel_reg;
        need_load_next  = need_load_reg;
        count_base      = countdown_reg;
        result          = '0;

        if (item.operation == xcr_pkg::OP_TICK)
        begin
            if (!started_reg && !finished_reg)
            begin
                if (countdown_reg == '0)
                begin
                    result.send_valid = 1'b1;
                    result.send_byte  = xcr_pkg::BYTE_C;
                    count_base        = prompt_interval;
                end
                countdown_next = count_base - xcr_pkg::PROMPT_W'(1);
            end
        end
        else
        begin
            case (phase_reg)
                xcr_pkg::PH_HEADER:
                begin
                    if (b == xcr_pkg::BYTE_EOT)
                    begin
                        result.send_valid = 1'b1;
                        result.send_byte  = xcr_pkg::BYTE_ACK;
                        result.done_res   = 1'b1;
                        finished_next     = 1'b1;
                        phase_next        = xcr_pkg::PH_DONE;
                    end
                    else if (b == xcr_pkg::BYTE_SOH)
                    begin
                        started_next = 1'b1;
                        crc_next     = '0;
                        phase_next   = xcr_pkg::PH_NUMBER;
                    end
                end
                xcr_pkg::PH_NUMBER:
                begin
                    block_next = b;
                    phase_next = xcr_pkg::PH_COMPL;
                end
                xcr_pkg::PH_COMPL:
                begin
                    if (need_load_reg)
                    begin
                        result.load_valid = 1'b1;
                        result.buffer_id  = buf_sel_reg;
                        result.flash_page = page_ext[11:0];
                        need_load_next    = 1'b0;
                    end
                    byte_index_next = '0;
                    phase_next      = xcr_pkg::PH_DATA;
                end
                xcr_pkg::PH_DATA:
                begin
                    crc_next            = xcr_pkg::crc_byte(crc_reg, b);
                    result.store_valid  = 1'b1;
                    result.store_offset = 8'(offset_reg) + 8'(byte_index_reg);
                    result.store_data   = b;
                    result.buffer_id    = buf_sel_reg;
                    result.flash_page   = page_ext[11:0];
                    if (byte_index_reg == xcr_pkg::BIDX_W'(xcr_pkg::BLOCK_BYTES - 1))
                    begin
                        byte_index_next = '0;
                        phase_next      = xcr_pkg::PH_CRC_HI;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + xcr_pkg::BIDX_W'(1);
                    end
                end
                xcr_pkg::PH_CRC_HI:
                begin
                    check_hi_next = b;
                    phase_next    = xcr_pkg::PH_CRC_LO;
                end
                xcr_pkg::PH_CRC_LO:
                begin
                    result.send_valid = 1'b1;
                    phase_next        = xcr_pkg::PH_HEADER;
                    if (crc_reg != {check_hi_reg, b})
                    begin
                        result.send_byte = xcr_pkg::BYTE_NAK;
                    end
                    else
                    begin
                        result.send_byte = xcr_pkg::BYTE_ACK;
                        // repeated block: acknowledge only
                        if (block_reg != prev_block_reg)
                        begin
                            offset_next = offset_adv;
                            if (offset_adv >= OFS_W'(PAGE_BYTES))
                            begin
                                result.commit_valid = 1'b1;
                                result.buffer_id    = buf_sel_reg;
                                result.flash_page   = page_ext[11:0];
                                need_load_next      = 1'b1;
                                buf_sel_next        = ~buf_sel_reg;
                                offset_next         = '0;
                                page_next           = page_reg + PAGE_BITS'(1);
                            end
                            prev_block_next = block_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/xmodem_crc_receiver.sv
// Top level of the XMODEM-CRC receiver: stream ports, input register, result register.
// Depends on xcr_pkg, xcr_core and xmodem_crc_receiver_defines.svh.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: rx_byte; s_tuser: operation
//  m_*     | out | m_tvalid/m_tready  | m_tdata: one result word
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: prompt_interval
//
// One word per cycle sustained while m_tready stays high; a result word reaches m_tdata
// through the input register, then one pass of the state machine into the result
// register.
// The CRC byte update is the longest path: eight shift/xor steps on 16 bits.
// rst_n resets all control state; prompt_interval resets to 500000.
// A stalled m side holds its word; s_tready drops only when both registers are full.
`include "xmodem_crc_receiver_defines.svh"

module xmodem_crc_receiver #(
    parameter int PAGE_BYTES = xcr_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_BITS  = xcr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                    s_tuser,   // [0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] send_valid, [8:1] send_byte, [9] load_valid, [10] store_valid,
    // [18:11] store_offset, [26:19] store_data, [27] commit_valid, [28] buffer_id,
    // [40:29] flash_page, [41] done_res, [47:42] zero
    output logic [xcr_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xcr_pkg::PROMPT_W-1:0]  cfg_data
);

    xcr_pkg::xcr_item_t           in_reg;
    logic                         in_valid_reg;
    xcr_pkg::xcr_result_t         out_reg;
    logic                         out_valid_reg;
    logic [xcr_pkg::PROMPT_W-1:0] prompt_reg;

    xcr_pkg::xcr_result_t         core_result;
    logic                         out_free;
    logic                         step;
    logic                         out_other_ops;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prompt_reg <= xcr_pkg::PROMPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prompt_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.operation <= s_tuser[0];
            in_reg.rx_byte   <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= core_result;
        end
    end

    xcr_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .item            (in_reg),
        .prompt_interval (prompt_reg),
        .result          (core_result)
    );

    assign m_tdata = {
        (xcr_pkg::TDATA_W - xcr_pkg::OUT_BITS)'(0),
        out_reg.done_res,
        out_reg.flash_page,
        out_reg.buffer_id,
        out_reg.commit_valid,
        out_reg.store_data,
        out_reg.store_offset,
        out_reg.store_valid,
        out_reg.load_valid,
        out_reg.send_byte,
        out_reg.send_valid
    };

    assign out_other_ops = out_reg.send_valid || out_reg.commit_valid || out_reg.load_valid;

    `XCR_ASSERT_NEXT(a_pipe_refill, in_valid_reg && out_free, out_valid_reg)
    `XCR_ASSERT_NOW(a_store_alone, out_valid_reg && out_reg.store_valid, !out_other_ops)
    `XCR_ASSERT_NOW(a_done_acks, out_valid_reg && out_reg.done_res, out_reg.send_valid && (out_reg.send_byte == xcr_pkg::BYTE_ACK))

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for xmodem_crc_receiver: prompts, blocks, CRC, page buffers.
// Built-in receiver predictor checks every result word; depends on xcr_pkg and the RTL.
module tb;
    import xcr_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } rx_item_t;

    typedef enum {BLK_NEW, BLK_BAD, BLK_REPEAT} blk_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [PROMPT_W-1:0]  cfg_data = '0;

    xmodem_crc_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rx_item_t    pending[$];
    xcr_result_t expected_words[$];
    logic        calm = 1'b0;
    logic [7:0]  last_good = 8'h00;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          n_prompts = 0, n_acks = 0, n_naks = 0, n_loads = 0, n_commits = 0, n_done = 0;

    // receiver predictor state
    logic [PROMPT_W-1:0]  prompt_interval = PROMPT_RESET;
    xcr_phase_t           rx_phase = PH_HEADER;
    logic                 rx_started = 1'b0;
    logic                 rx_finished = 1'b0;
    logic [PROMPT_W-1:0]  prompt_count = '0;
    logic [15:0]          crc_acc = '0;
    logic [15:0]          rx_check = '0;
    logic [7:0]           blk_num = '0;
    logic [7:0]           prev_blk_num = '0;
    logic [6:0]           byte_idx = '0;
    logic [15:0]          buf_offset = '0;
    logic [PAGE_BITS_DEF-1:0] page_num = '0;
    logic                 buf_sel = 1'b0;
    logic                 need_load = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // CRC-16/XMODEM, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = crc[15] ^ d[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic xcr_result_t step_receiver(logic op, logic [7:0] b);
        xcr_result_t r;
        r = '0;
        if (op == OP_TICK)
        begin
            if (!rx_started && !rx_finished)
            begin
                if (prompt_count == '0)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = BYTE_C;
                    prompt_count = prompt_interval;
                end
                prompt_count = prompt_count - 1'b1;
            end
        end
        else
        begin
            case (rx_phase)
                PH_HEADER:
                begin
                    if (b == BYTE_EOT)
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte = BYTE_ACK;
                        r.done_res = 1'b1;
                        rx_finished = 1'b1;
                        rx_phase = PH_DONE;
                    end
                    else if (b == BYTE_SOH)
                    begin
                        rx_started = 1'b1;
                        crc_acc = '0;
                        rx_phase = PH_NUMBER;
                    end
                end
                PH_NUMBER:
                begin
                    blk_num = b;
                    rx_phase = PH_COMPL;
                end
                PH_COMPL:
                begin
                    if (need_load)
                    begin
                        r.load_valid = 1'b1;
                        r.buffer_id = buf_sel;
                        r.flash_page = 12'(page_num);
                        need_load = 1'b0;
                    end
                    byte_idx = '0;
                    rx_phase = PH_DATA;
                end
                PH_DATA:
                begin
                    crc_acc = crc16_step(crc_acc, b);
                    r.store_valid = 1'b1;
                    r.store_offset = 8'(buf_offset + 16'(byte_idx));
                    r.store_data = b;
                    r.buffer_id = buf_sel;
                    r.flash_page = 12'(page_num);
                    if (byte_idx == 7'd127)
                    begin
                        byte_idx = '0;
                        rx_phase = PH_CRC_HI;
                    end
                    else
                        byte_idx = byte_idx + 1'b1;
                end
                PH_CRC_HI:
                begin
                    rx_check = {b, 8'h00};
                    rx_phase = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    rx_check = {rx_check[15:8], b};
                    r.send_valid = 1'b1;
                    rx_phase = PH_HEADER;
                    if (crc_acc != rx_check)
                        r.send_byte = BYTE_NAK;
                    else
                    begin
                        r.send_byte = BYTE_ACK;
                        if (blk_num != prev_blk_num)
                        begin
                            buf_offset = buf_offset + 16'd128;
                            if (buf_offset >= 16'(PAGE_BYTES_DEF))
                            begin
                                r.commit_valid = 1'b1;
                                r.buffer_id = buf_sel;
                                r.flash_page = 12'(page_num);
                                need_load = 1'b1;
                                buf_sel = ~buf_sel;
                                buf_offset = '0;
                                page_num = page_num + 1'b1;
                            end
                            prev_blk_num = blk_num;
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at result word %0d: %s", words_out, what);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic logic roll_idle();
        return !calm && ($urandom_range(0, 99) < 6);
    endfunction

    // driver
    always @(posedge clk)
    begin : drive
        rx_item_t    nxt;
        xcr_result_t r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                r = step_receiver(s_tuser[0], s_tdata);
                expected_words.push_back(r);
                words_in++;
                if (r.send_valid && r.send_byte == BYTE_C)
                    n_prompts++;
                if (r.send_valid && r.send_byte == BYTE_ACK)
                    n_acks++;
                if (r.send_valid && r.send_byte == BYTE_NAK)
                    n_naks++;
                n_loads += r.load_valid;
                n_commits += r.commit_valid;
                n_done += r.done_res;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending.size() > 0 && !roll_idle())
                begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.op;
                    s_tdata <= nxt.data;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch
        xcr_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word 0x%0h", m_tdata));
                else
                begin
                    want = expected_words.pop_front();
                    check_field("send_valid", m_tdata[0], want.send_valid);
                    check_field("send_byte", m_tdata[8:1], want.send_byte);
                    check_field("load_valid", m_tdata[9], want.load_valid);
                    check_field("store_valid", m_tdata[10], want.store_valid);
                    check_field("store_offset", m_tdata[18:11], want.store_offset);
                    check_field("store_data", m_tdata[26:19], want.store_data);
                    check_field("commit_valid", m_tdata[27], want.commit_valid);
                    check_field("buffer_id", m_tdata[28], want.buffer_id);
                    check_field("flash_page", m_tdata[40:29], want.flash_page);
                    check_field("done_res", m_tdata[41], want.done_res);
                end
                words_out++;
            end
            m_tready <= !roll_idle();
        end
    end

    task automatic push_item(logic op, logic [7:0] d);
        rx_item_t it;
        it.op = op;
        it.data = d;
        pending.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_interval(logic [PROMPT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        prompt_interval = v;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 15))
            0: return BYTE_SOH;
            1: return BYTE_EOT;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // header noise: ticks and bytes that are neither SOH nor EOT
    task automatic queue_gap_noise();
        logic [7:0] b;
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 1))
                push_item(OP_TICK, 8'($urandom));
            else
            begin
                do
                    b = 8'($urandom);
                while (b == BYTE_SOH || b == BYTE_EOT);
                push_item(OP_BYTE, b);
            end
        end
    endtask

    task automatic queue_block(blk_kind_t kind);
        logic [7:0]  num;
        logic [7:0]  d;
        logic [15:0] crc;
        if (kind == BLK_REPEAT)
            num = last_good;
        else if ($urandom_range(0, 3) == 0)
        begin
            do
                num = 8'($urandom);
            while (num == last_good);
        end
        else
            num = last_good + 1'b1;
        crc = '0;
        push_item(OP_BYTE, BYTE_SOH);
        push_item(OP_BYTE, num);
        push_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : ~num);
        for (int k = 0; k < 128; k++)
        begin
            d = pick_data();
            crc = crc16_step(crc, d);
            if ($urandom_range(0, 19) == 0)
                push_item(OP_TICK, 8'($urandom));
            push_item(OP_BYTE, d);
        end
        if (kind == BLK_BAD)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        else
            last_good = num;
        push_item(OP_BYTE, crc[15:8]);
        push_item(OP_BYTE, crc[7:0]);
    endtask

    initial
    begin : stimulus
        blk_kind_t plan[2];
        plan = '{BLK_BAD, BLK_NEW};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // prompt every tick, header noise ignored
        write_interval(20'd1);
        push_item(OP_TICK, 8'h00);
        push_item(OP_TICK, 8'hFF);
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, BYTE_ACK);
        push_item(OP_BYTE, BYTE_NAK);
        push_item(OP_BYTE, BYTE_C);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, 8'h7F);
        push_item(OP_TICK, 8'h00);
        wait_drained();

        write_interval(20'd3);
        repeat (3) push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, 8'h55);
        repeat (3) push_item(OP_TICK, 8'hAA);
        wait_drained();

        // zero reload wraps the countdown
        write_interval(20'd0);
        repeat (3) push_item(OP_TICK, 8'h00);
        wait_drained();

        write_interval(PROMPT_W'($urandom_range(1, 1048575)));
        calm = 1'b1;
        queue_block(BLK_NEW);
        wait_drained();
        calm = 1'b0;

        foreach (plan[i])
        begin
            queue_gap_noise();
            queue_block(plan[i]);
            if (i == 0)
            begin
                wait_drained();
                write_interval(20'hFFFFF);
            end
        end
        queue_gap_noise();

        // end of transfer, then everything is ignored
        push_item(OP_BYTE, BYTE_EOT);
        push_item(OP_BYTE, BYTE_SOH);
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, BYTE_EOT);
        push_item(OP_BYTE, 8'($urandom));
        wait_drained();
        repeat (8) @(negedge clk);

        $display("Covered %0d input words and %0d result words, prompt intervals 0 to max.",
                 words_in, words_out);
        $display("Seen %0d prompts, %0d ACK, %0d NAK, %0d loads, %0d commits, %0d end.",
                 n_prompts, n_acks, n_naks, n_loads, n_commits, n_done);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/xcr_pkg.sv
rtl/core/xcr_core.sv
rtl/core/xmodem_crc_receiver.sv
tb/sv/tb.sv
